### hw/rtl/lkts_pkg.sv
package lkts_pkg;

    localparam int MAX_KEYS_DEF = 256;
    localparam int CMD_W        = 2;
    localparam int FRAME_W      = 24;
    localparam int WEIGHT_W     = 16;
    localparam int POS_W        = 32;
    localparam int FRAC_W       = 8;
    localparam int ENTRY_W      = FRAME_W + WEIGHT_W;
    localparam int DIFF_W       = WEIGHT_W + 1;
    localparam int PROD_W       = POS_W + WEIGHT_W;
    localparam int QUOT_W       = WEIGHT_W + 1;
    localparam int REM_W        = POS_W;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_SAMPLE = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS,
        ST_INS_CHK,
        ST_RD_FIRST,
        ST_CHK_FIRST,
        ST_RD_LAST,
        ST_CHK_LAST,
        ST_SRCH,
        ST_SRCH_CHK,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [REM_W-1:0]  divisor;
    } div_req_t;

endpackage

### hw/rtl/lkts_div.sv
module lkts_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lkts_pkg::div_req_t                req,
    output logic                              done,
    output logic [lkts_pkg::QUOT_W-1:0]       quotient
);

    localparam int QW  = lkts_pkg::QUOT_W;
    localparam int RW  = lkts_pkg::REM_W;
    localparam int PW  = lkts_pkg::PROD_W;
    localparam int CNW = $clog2(QW + 1);

    logic [RW-1:0]  rem_reg, rem_next;
    logic [RW-1:0]  den_reg, den_next;
    logic [QW-1:0]  sh_reg, sh_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [RW:0]    trial;
    logic           ge;

    // restoring divide, one quotient bit per cycle; quotient fits in QW bits
    always_comb begin
        trial     = {rem_reg, sh_reg[QW-1]};
        ge        = trial >= {1'b0, den_reg};
        rem_next  = rem_reg;
        den_next  = den_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = RW'(req.dividend[PW-1:QW]);
            sh_next   = req.dividend[QW-1:0];
            den_next  = req.divisor;
            cnt_next  = CNW'(QW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? RW'(trial - {1'b0, den_reg}) : trial[RW-1:0];
            sh_next  = {sh_reg[QW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        sh_reg  <= sh_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = sh_reg;

endmodule

### hw/rtl/linear_keyframe_track_sampler.sv
// clear, unused command, empty-table sample: result valid 1 cycle after the input beat
// insert: 2*k + 3 cycles, 2*k + 2 when the key lands in slot 0, k = keys with a later frame
// sample: 3 cycles below the first key, 5 at or past the last, else 26 + 2*s cycles,
// s = search steps (about log2 of the key count), 18 of them in the serial divider
// one item at a time plus any wait for the result register, next beat taken once the
// result is loaded; synchronous reset empties the table, key memory not cleared
module linear_keyframe_track_sampler #(
    parameter int MAX_KEYS = lkts_pkg::MAX_KEYS_DEF,
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1,
    localparam int CW = $clog2(MAX_KEYS + 1)
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [lkts_pkg::CMD_W-1:0]           s_command,
    input  logic [lkts_pkg::FRAME_W-1:0]         s_key_frame,
    input  logic signed [lkts_pkg::WEIGHT_W-1:0] s_key_weight,
    input  logic [lkts_pkg::POS_W-1:0]           s_sample_position,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [lkts_pkg::WEIGHT_W-1:0] m_sampled_weight,
    output logic                                 m_table_full,
    output logic [CW-1:0]                        m_stored_keys
);

    localparam int FW = lkts_pkg::FRAME_W;
    localparam int WW = lkts_pkg::WEIGHT_W;
    localparam int PW = lkts_pkg::POS_W;
    localparam int XW = lkts_pkg::FRAC_W;
    localparam int EW = lkts_pkg::ENTRY_W;
    localparam int DW = lkts_pkg::DIFF_W;
    localparam int MW = lkts_pkg::PROD_W;
    localparam int QW = lkts_pkg::QUOT_W;

    lkts_pkg::state_t state_reg, state_next;

    logic [EW-1:0] mem [MAX_KEYS];
    logic [EW-1:0] rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [EW-1:0] mem_wd;

    logic [CW-1:0]        count_reg, count_next;
    logic [FW-1:0]        kf_reg, kf_next;
    logic signed [WW-1:0] kw_reg, kw_next;
    logic [PW-1:0]        sp_reg, sp_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [AW-1:0]        lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [FW-1:0]        flo_reg, flo_next, fhi_reg, fhi_next;
    logic signed [WW-1:0] wlo_reg, wlo_next, whi_reg, whi_next;
    logic [MW-1:0]        prod_reg, prod_next;
    logic                 neg_reg, neg_next;
    logic signed [WW-1:0] res_w_reg, res_w_next;
    logic                 res_full_reg, res_full_next;
    logic                 m_valid_reg, m_valid_next;
    logic signed [WW-1:0] m_w_reg, m_w_next;
    logic                 m_full_reg, m_full_next;
    logic [CW-1:0]        m_keys_reg, m_keys_next;

    logic [FW-1:0]        rd_f;
    logic signed [WW-1:0] rd_w;
    logic                 full;
    logic                 out_free;
    logic [AW:0]          mid_sum;
    logic                 more;
    logic [PW-1:0]        delta;
    logic signed [DW-1:0] diff;
    logic [DW-1:0]        diff_mag;
    logic [DW-1:0]        q_signed;
    logic [DW-1:0]        sum;

    lkts_pkg::div_req_t   div_req;
    logic                 div_done;
    logic [QW-1:0]        div_q;

    lkts_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    assign rd_f     = rd_data_reg[EW-1:WW];
    assign rd_w     = rd_data_reg[WW-1:0];
    assign full     = count_reg == CW'(MAX_KEYS);
    assign out_free = !m_valid_reg || m_ready;
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign more     = ({1'b0, lo_reg} + 1'b1) < {1'b0, hi_reg};
    assign delta    = sp_reg - {flo_reg, {XW{1'b0}}};
    assign diff     = DW'(whi_reg) - DW'(wlo_reg);
    assign diff_mag = diff[DW-1] ? DW'(-diff) : DW'(diff);
    assign q_signed = neg_reg ? DW'(-{1'b0, div_q[WW-1:0]}) : {1'b0, div_q[WW-1:0]};
    assign sum      = DW'(wlo_reg) + q_signed;
    assign s_ready  = state_reg == lkts_pkg::ST_IDLE;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lkts_pkg::ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_command)
                        lkts_pkg::CMD_INSERT:
                            state_next = full ? lkts_pkg::ST_FIN : lkts_pkg::ST_INS;
                        lkts_pkg::CMD_SAMPLE:
                            state_next = (count_reg == '0) ? lkts_pkg::ST_FIN
                                                           : lkts_pkg::ST_RD_FIRST;
                        default: state_next = lkts_pkg::ST_FIN;
                    endcase
                end
            end
            lkts_pkg::ST_INS: begin
                state_next = (pos_reg == '0) ? lkts_pkg::ST_FIN : lkts_pkg::ST_INS_CHK;
            end
            lkts_pkg::ST_INS_CHK: begin
                state_next = (rd_f > kf_reg) ? lkts_pkg::ST_INS : lkts_pkg::ST_FIN;
            end
            lkts_pkg::ST_RD_FIRST: state_next = lkts_pkg::ST_CHK_FIRST;
            lkts_pkg::ST_CHK_FIRST: begin
                state_next = (sp_reg <= {rd_f, {XW{1'b0}}}) ? lkts_pkg::ST_FIN
                                                             : lkts_pkg::ST_RD_LAST;
            end
            lkts_pkg::ST_RD_LAST: state_next = lkts_pkg::ST_CHK_LAST;
            lkts_pkg::ST_CHK_LAST: begin
                state_next = (sp_reg >= {rd_f, {XW{1'b0}}}) ? lkts_pkg::ST_FIN
                                                             : lkts_pkg::ST_SRCH;
            end
            lkts_pkg::ST_SRCH: begin
                state_next = more ? lkts_pkg::ST_SRCH_CHK : lkts_pkg::ST_MUL;
            end
            lkts_pkg::ST_SRCH_CHK: state_next = lkts_pkg::ST_SRCH;
            lkts_pkg::ST_MUL: begin
                state_next = (fhi_reg == flo_reg) ? lkts_pkg::ST_FIN : lkts_pkg::ST_DIV_GO;
            end
            lkts_pkg::ST_DIV_GO: state_next = lkts_pkg::ST_DIV_WAIT;
            lkts_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = lkts_pkg::ST_FIN;
                end
            end
            lkts_pkg::ST_FIN: begin
                if (out_free) begin
                    state_next = lkts_pkg::ST_IDLE;
                end
            end
            default: state_next = lkts_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        mem_we        = 1'b0;
        mem_wa        = pos_reg;
        mem_wd        = {kf_reg, kw_reg};
        mem_ra        = '0;
        count_next    = count_reg;
        kf_next       = kf_reg;
        kw_next       = kw_reg;
        sp_next       = sp_reg;
        pos_next      = pos_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        flo_next      = flo_reg;
        fhi_next      = fhi_reg;
        wlo_next      = wlo_reg;
        whi_next      = whi_reg;
        prod_next     = prod_reg;
        neg_next      = neg_reg;
        res_w_next    = res_w_reg;
        res_full_next = res_full_reg;
        div_req       = '{start: 1'b0, dividend: prod_reg,
                          divisor: {fhi_reg - flo_reg, {XW{1'b0}}}};
        m_valid_next  = m_valid_reg && !m_ready;
        m_w_next      = m_w_reg;
        m_full_next   = m_full_reg;
        m_keys_next   = m_keys_reg;
        unique case (state_reg)
            lkts_pkg::ST_IDLE: begin
                if (s_valid) begin
                    kf_next       = s_key_frame;
                    kw_next       = s_key_weight;
                    sp_next       = s_sample_position;
                    pos_next      = count_reg[AW-1:0];
                    res_w_next    = '0;
                    res_full_next = (s_command == lkts_pkg::CMD_INSERT) && full;
                    if (s_command == lkts_pkg::CMD_CLEAR) begin
                        count_next = '0;
                    end
                end
            end
            lkts_pkg::ST_INS: begin
                mem_ra = pos_reg - 1'b1;
                if (pos_reg == '0) begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            lkts_pkg::ST_INS_CHK: begin
                mem_we = 1'b1;
                if (rd_f > kf_reg) begin
                    mem_wd   = rd_data_reg;
                    pos_next = pos_reg - 1'b1;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            lkts_pkg::ST_RD_FIRST: mem_ra = '0;
            lkts_pkg::ST_CHK_FIRST: begin
                flo_next   = rd_f;
                wlo_next   = rd_w;
                res_w_next = rd_w;
            end
            lkts_pkg::ST_RD_LAST: mem_ra = AW'(count_reg - 1'b1);
            lkts_pkg::ST_CHK_LAST: begin
                fhi_next   = rd_f;
                whi_next   = rd_w;
                res_w_next = rd_w;
                lo_next    = '0;
                hi_next    = AW'(count_reg - 1'b1);
            end
            lkts_pkg::ST_SRCH: begin
                mid_next = mid_sum[AW:1];
                mem_ra   = mid_sum[AW:1];
            end
            lkts_pkg::ST_SRCH_CHK: begin
                if (rd_f <= sp_reg[PW-1:XW]) begin
                    lo_next  = mid_reg;
                    flo_next = rd_f;
                    wlo_next = rd_w;
                end else begin
                    hi_next  = mid_reg;
                    fhi_next = rd_f;
                    whi_next = rd_w;
                end
            end
            lkts_pkg::ST_MUL: begin
                res_w_next = wlo_reg;
                prod_next  = delta * diff_mag[WW-1:0];
                neg_next   = diff[DW-1];
            end
            lkts_pkg::ST_DIV_GO: div_req.start = 1'b1;
            lkts_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    res_w_next = sum[WW-1:0];
                end
            end
            lkts_pkg::ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_w_next     = res_w_reg;
                    m_full_next  = res_full_reg;
                    m_keys_next  = count_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    always_ff @(posedge aclk) begin
        kf_reg       <= kf_next;
        kw_reg       <= kw_next;
        sp_reg       <= sp_next;
        pos_reg      <= pos_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        flo_reg      <= flo_next;
        fhi_reg      <= fhi_next;
        wlo_reg      <= wlo_next;
        whi_reg      <= whi_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        res_w_reg    <= res_w_next;
        res_full_reg <= res_full_next;
        m_w_reg      <= m_w_next;
        m_full_reg   <= m_full_next;
        m_keys_reg   <= m_keys_next;
        if (!aresetn) begin
            state_reg   <= lkts_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_sampled_weight = m_w_reg;
    assign m_table_full     = m_full_reg;
    assign m_stored_keys    = m_keys_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_KEYS))
        else $error("key count above table size");

    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !full)
        else $error("key memory written while table full");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == lkts_pkg::ST_DIV_WAIT)
        else $error("divider finished outside wait state");

    a_fin_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lkts_pkg::ST_FIN && out_free) |=> m_valid_reg)
        else $error("result not presented after finish");
`endif

endmodule

### tb/tb_linear_keyframe_track_sampler.sv
module tb_linear_keyframe_track_sampler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NKEYS = lkts_pkg::MAX_KEYS_DEF;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int CMDW = lkts_pkg::CMD_W;
    localparam int FW = lkts_pkg::FRAME_W;
    localparam int WW = lkts_pkg::WEIGHT_W;
    localparam int PW = lkts_pkg::POS_W;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMDW-1:0] command;
        logic [FW-1:0]   frame;
        logic [WW-1:0]   weight;
        logic [PW-1:0]   position;
    } track_op_t;

    typedef struct packed {
        logic [WW-1:0] weight;
        logic          full;
        logic [8:0]    keys;
    } track_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CMDW-1:0] s_command = '0;
    logic [FW-1:0] s_key_frame = '0;
    logic signed [WW-1:0] s_key_weight = '0;
    logic [PW-1:0] s_sample_position = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [WW-1:0] m_sampled_weight;
    logic m_table_full;
    logic [8:0] m_stored_keys;

    linear_keyframe_track_sampler dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_key_frame(s_key_frame), .s_key_weight(s_key_weight),
        .s_sample_position(s_sample_position),
        .m_valid(m_valid), .m_ready(m_ready), .m_sampled_weight(m_sampled_weight),
        .m_table_full(m_table_full), .m_stored_keys(m_stored_keys)
    );

    always #10 aclk = ~aclk;

    track_op_t pending_ops[$];
    track_result_t expected_results[$];
    logic [FW-1:0] key_frames[NKEYS];
    logic signed [WW-1:0] key_weights[NKEYS];
    int key_count = 0;
    int mismatches = 0;
    int accepted_ops = 0;
    int checked_results = 0;
    int cycles = 0;
    int sample_count = 0;
    int full_count = 0;
    bit calm = 0;
    int src_gap = 0;
    int snk_gap = 0;
    logic in_taken = 1'b0;

    function automatic logic signed [WW-1:0] sample_weight(logic [PW-1:0] pos);
        int lo, hi, mid;
        longint span, delta, diff, num;
        logic [31:0] whole;
        if (key_count == 0) return '0;
        if ({32'd0, pos} <= {40'd0, key_frames[0]} << 8) return key_weights[0];
        if ({32'd0, pos} >= {40'd0, key_frames[key_count-1]} << 8)
            return key_weights[key_count-1];
        whole = pos >> 8;
        lo = 0;
        hi = key_count - 1;
        while (lo + 1 < hi) begin
            mid = (lo + hi) / 2;
            if ({8'd0, key_frames[mid]} <= whole) lo = mid;
            else hi = mid;
        end
        span = longint'(key_frames[hi]) - longint'(key_frames[lo]);
        if (span <= 0) return key_weights[lo];
        delta = longint'(pos) - longint'(key_frames[lo]) * 256;
        diff = longint'(key_weights[hi]) - longint'(key_weights[lo]);
        num = delta * diff;
        return WW'(longint'(key_weights[lo]) + num / (span * 256));
    endfunction

    function automatic track_result_t apply_op(track_op_t op);
        track_result_t r;
        int p;
        r = '0;
        case (op.command)
            lkts_pkg::CMD_CLEAR: key_count = 0;
            lkts_pkg::CMD_INSERT: begin
                if (key_count >= NKEYS) begin
                    r.full = 1'b1;
                end else begin
                    p = key_count;
                    while (p > 0 && key_frames[p-1] > op.frame) begin
                        key_frames[p] = key_frames[p-1];
                        key_weights[p] = key_weights[p-1];
                        p--;
                    end
                    key_frames[p] = op.frame;
                    key_weights[p] = op.weight;
                    key_count++;
                end
            end
            lkts_pkg::CMD_SAMPLE: r.weight = sample_weight(op.position);
            default: ;
        endcase
        r.keys = 9'(key_count);
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 checked_results, what, got, want);
        mismatches++;
    endtask

    function automatic track_op_t make_op(logic [1:0] c, logic [FW-1:0] f,
                                          logic [WW-1:0] w, logic [PW-1:0] p);
        track_op_t op;
        op.command = c;
        op.frame = f;
        op.weight = w;
        op.position = p;
        return op;
    endfunction

    task automatic add_op(track_op_t op);
        pending_ops = {pending_ops, op};
    endtask

    function automatic logic [PW-1:0] rand_pos(logic [FW-1:0] f_lo, int range);
        longint top;
        logic [31:0] offset;
        top = longint'(range) * 256 + 511;
        if (top > longint'(32'hffff_ffff)) top = longint'(32'hffff_ffff);
        offset = $urandom_range(0, 32'(top));
        return ({8'd0, f_lo} << 8) + offset - 32'd256;
    endfunction

    // input accept and prediction
    always @(posedge aclk) begin
        track_result_t r;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("cycle limit reached");
            $display("simulation failed");
            $finish;
        end
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            accepted_ops++;
            r = apply_op(pending_ops.pop_front());
            expected_results = {expected_results, r};
        end
    end

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    s_valid <= 1'b1;
                    s_command <= pending_ops[0].command;
                    s_key_frame <= pending_ops[0].frame;
                    s_key_weight <= pending_ops[0].weight;
                    s_sample_position <= pending_ops[0].position;
                    if (!calm && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 14);
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) snk_gap = $urandom_range(1, 14);
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        track_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("unexpected result beat");
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (m_sampled_weight !== want.weight)
                    report("sampled_weight", 32'(m_sampled_weight), 32'(want.weight));
                if (m_table_full !== want.full)
                    report("table_full", 32'(m_table_full), 32'(want.full));
                if (m_stored_keys !== want.keys)
                    report("stored_keys", 32'(m_stored_keys), 32'(want.keys));
                checked_results++;
            end
        end
    end

    task automatic queue_track(int n, int frame_range);
        logic [FW-1:0] base;
        int i;
        base = FW'($urandom_range(0, 16777215 - frame_range));
        add_op(make_op(lkts_pkg::CMD_CLEAR, FW'($urandom), WW'($urandom), $urandom));
        for (i = 0; i < n; i++)
            add_op(make_op(lkts_pkg::CMD_INSERT, FW'(base + $urandom_range(0, frame_range)),
                           WW'($urandom), $urandom));
        for (i = 0; i < n + 4; i++) begin
            add_op(make_op(lkts_pkg::CMD_SAMPLE, FW'($urandom), WW'($urandom),
                           rand_pos(base, frame_range)));
            sample_count++;
        end
    endtask

    initial begin
        int i, total;
        // directed
        add_op(make_op(lkts_pkg::CMD_SAMPLE, '0, '0, 32'h0000_0100));
        add_op(make_op(lkts_pkg::CMD_INSERT, 24'd10, 16'sh7fff, '0));
        add_op(make_op(lkts_pkg::CMD_SAMPLE, '0, '0, 32'd0));
        add_op(make_op(lkts_pkg::CMD_SAMPLE, '0, '0, 32'hffff_ffff));
        add_op(make_op(lkts_pkg::CMD_INSERT, 24'hffffff, 16'sh8000, '0));
        add_op(make_op(lkts_pkg::CMD_INSERT, 24'd10, 16'sh1234, '0));
        add_op(make_op(lkts_pkg::CMD_INSERT, 24'd0, 16'sh0000, '0));
        add_op(make_op(lkts_pkg::CMD_SAMPLE, '0, '0, 32'h0000_0a00));
        add_op(make_op(lkts_pkg::CMD_SAMPLE, '0, '0, 32'h0000_0a80));
        add_op(make_op(lkts_pkg::CMD_SAMPLE, '0, '0, 32'h0000_0501));
        add_op(make_op(lkts_pkg::CMD_SAMPLE, '0, '0, 32'h8000_0000));
        add_op(make_op(lkts_pkg::CMD_SAMPLE, '0, '0, 32'hffff_feff));
        add_op(make_op(CMD_UNUSED, 24'hffffff, 16'hffff, 32'hffff_ffff));
        add_op(make_op(lkts_pkg::CMD_CLEAR, '0, '0, '0));
        add_op(make_op(lkts_pkg::CMD_SAMPLE, '0, '0, 32'h0000_0a00));
        // fill to capacity, then overfill
        for (i = 0; i < NKEYS + 3; i++) begin
            add_op(make_op(lkts_pkg::CMD_INSERT, FW'($urandom_range(0, 300)),
                           WW'($urandom), '0));
            if (i >= NKEYS) full_count++;
        end
        for (i = 0; i < 30; i++)
            add_op(make_op(lkts_pkg::CMD_SAMPLE, '0, '0, $urandom_range(0, 310 * 256)));
        // random tracks, mostly short
        total = pending_ops.size();
        while (total < 1130) begin
            if ($urandom_range(0, 9) == 0)
                add_op(make_op(2'($urandom_range(0, 3)), FW'($urandom), WW'($urandom),
                               $urandom));
            else
                queue_track($urandom_range(1, 12),
                            $urandom_range(0, 1) ? $urandom_range(1, 40) :
                                                   $urandom_range(1, 16777215));
            total = pending_ops.size();
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        wait (pending_ops.size() < 60);
        calm = 1;
        wait (pending_ops.size() == 0 && !s_valid);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge aclk);
        $display("ran %0d operations with %0d results checked", accepted_ops, checked_results);
        $display("%0d random samples, %0d refused inserts, plus empty, clamp and tie cases",
                 sample_count, full_count);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

### filelist.f
hw/rtl/lkts_pkg.sv
hw/rtl/lkts_div.sv
hw/rtl/linear_keyframe_track_sampler.sv
tb/tb_linear_keyframe_track_sampler.sv
